### sv/ffaa_pkg.sv
// Package for the first-fit aligned allocator: widths, status codes, opcodes,
// reset capacity and remainder unit interface types. No dependencies.
package ffaa_pkg;
  localparam int MaxExtents = 64;
  localparam int IdxBits    = $clog2(MaxExtents);
  localparam int CntBits    = IdxBits + 1;
  localparam int OfsBits    = 32;
  localparam int AlignBits  = 17;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ZALGN = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [31:0] CapReset = 32'd65536;

  typedef struct packed {
    logic                 start;
    logic [OfsBits-1:0]   dividend;
    logic [AlignBits-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [AlignBits-1:0] rem;
  } div_rsp_t;
endpackage

### sv/ffaa_rem_unit.sv
// Restoring remainder unit, one quotient bit per cycle.
// Depends on ffaa_pkg.
module ffaa_rem_unit (
  input  logic              clk,
  input  logic              rst,
  input  ffaa_pkg::div_req_t req,
  output ffaa_pkg::div_rsp_t rsp
);
  import ffaa_pkg::*;

  logic [OfsBits-1:0]       dvd;
  logic [AlignBits-1:0]     dvs;
  logic [AlignBits:0]       rem;
  logic [$clog2(OfsBits):0] cnt;
  logic                     busy;
  logic                     done;
  logic [AlignBits+1:0]     trial;

  assign trial = {rem, dvd[OfsBits-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        dvd  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        // shift in one dividend bit, subtract when it fits
        if (trial >= {2'b0, dvs}) begin
          rem <= (AlignBits+1)'(trial - {2'b0, dvs});
        end else begin
          rem <= trial[AlignBits:0];
        end
        dvd <= {dvd[OfsBits-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(OfsBits)+1)'(OfsBits - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.rem  = rem[AlignBits-1:0];
endmodule

### sv/first_fit_aligned_allocator_core.sv
// Top level of the first-fit aligned allocator: APB register, stream ports,
// sequencer and extent table memory. Depends on ffaa_pkg and ffaa_rem_unit.
//
//  channel | dir | beat contents
//  s_axis  | in  | tdata: opcode[0], size_bytes[32:1], align_bytes[49:33],
//          |     |        release_offset[81:50], zero fill to 88 bits
//  m_axis  | out | tdata: status[1:0], granted_offset[33:2], used_bytes[65:34],
//          |     |        free_bytes[97:66], live_allocations[129:98], fill to 136
//  apb     | cfg | capacity at address 0
//
// One beat at a time. An allocate visits each extent scanned with the table
// read (S_RD, S_CHK), the remainder (start, one step per dividend bit, done)
// and the fit check (S_FIT). A free scans each extent through S_RD, S_CHK and
// S_FSCAN. Insert or erase then shifts the table one entry at a time through
// the S_SHRD, S_SHWR and S_FPRV states. Reset and capacity writes
// clear the table through the count only (entries beyond the count are never
// read). The result moves into an output register; s_axis tready is low while
// a beat is in progress, while that register still holds an unaccepted
// result at the end of a beat, and during an APB write.
module first_fit_aligned_allocator_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [0:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [87:0]  s_axis_tdata,  // opcode, size_bytes, align_bytes, release_offset
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata   // status, granted_offset, used, free, live
);
  import ffaa_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD     = 4'd1;
  localparam logic [3:0] S_CHK    = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_FIT    = 4'd4;
  localparam logic [3:0] S_FSCAN  = 4'd5;
  localparam logic [3:0] S_FPRV   = 4'd6;
  localparam logic [3:0] S_FDEC   = 4'd7;
  localparam logic [3:0] S_SHRD   = 4'd8;
  localparam logic [3:0] S_SHWR   = 4'd9;
  localparam logic [3:0] S_FINAL  = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  // extent table memory: one write port and one read port, registered read
  logic [2*OfsBits-1:0] mem [MaxExtents];
  logic                 we;
  logic [IdxBits-1:0]   waddr, raddr;
  logic [2*OfsBits-1:0] wdata, rdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  logic [3:0]           state;
  logic [31:0]          capacity;
  logic [CntBits-1:0]   count;
  logic [31:0]          used, tally;
  logic                 op;
  logic [OfsBits-1:0]   size, off;
  logic [AlignBits-1:0] align;
  logic [CntBits-1:0]   idx;
  logic [OfsBits-1:0]   cst, cln, pst, pln, nst, nln;
  logic [1:0]           status;
  logic [OfsBits-1:0]   granted;
  // deferred single write and shift plan
  logic                 shift_up, shift_dn, bump;
  logic [CntBits-1:0]   sidx, stop;
  logic [2*OfsBits-1:0] hold_ent, ins_ent;
  logic [IdxBits-1:0]   ins_at;
  logic                 ins_en;
  div_req_t             dreq;
  div_rsp_t             drsp;

  ffaa_rem_unit u_rem (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? capacity : 32'd0;

  logic [OfsBits:0] waste, need;
  assign waste = (drsp.rem == '0) ? '0 : {{(OfsBits+1-AlignBits){1'b0}}, align - drsp.rem};
  assign need  = waste + {1'b0, size};

  logic [32:0] usum;
  assign usum = {1'b0, used} + {1'b0, size};

  // result register: lets the next beat start while a result waits
  logic         out_valid;
  logic         out_load;
  logic [135:0] out_data;

  assign s_axis_tready = (state == S_IDLE) && !cfg_wr;
  assign out_load      = (state == S_OUT) && !cfg_wr && (!out_valid || m_axis_tready);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= {6'd0, tally, (capacity > used) ? capacity - used : 32'd0,
                   used, (status == ST_OK) ? granted : 32'd0, status};
    end
  end

  always_ff @(posedge clk) begin
    we <= 1'b0;
    dreq.start <= 1'b0;
    if (rst) begin
      state    <= S_IDLE;
      capacity <= CapReset;
      count    <= CntBits'(1);
      used     <= '0;
      tally    <= '0;
      we       <= 1'b1;
      waddr    <= '0;
      wdata    <= {CapReset, {OfsBits{1'b0}}};
    end else if (cfg_wr) begin
      if (paddr == 1'b0) begin
        capacity <= pwdata;
        count    <= (pwdata != 0) ? CntBits'(1) : '0;
        used     <= '0;
        tally    <= '0;
        we       <= 1'b1;
        waddr    <= '0;
        wdata    <= {pwdata, {OfsBits{1'b0}}};
      end
    end else begin
      unique case (state)
        S_IDLE: if (s_axis_tvalid) begin
          op      <= s_axis_tdata[0];
          size    <= s_axis_tdata[32:1];
          align   <= s_axis_tdata[49:33];
          off     <= s_axis_tdata[81:50];
          idx     <= '0;
          status  <= ST_OK;
          granted <= '0;
          shift_up <= 1'b0; shift_dn <= 1'b0; ins_en <= 1'b0; bump <= 1'b0;
          pst <= '0; pln <= '0;
          if (s_axis_tdata[32:1] == '0) state <= S_OUT;
          else if (s_axis_tdata[0] == OP_ALLOC && s_axis_tdata[49:33] == '0) begin
            status <= ST_ZALGN;
            state  <= S_OUT;
          end else begin
            raddr <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          if (op == OP_FREE && idx >= count) begin
            // free scan ran past the last entry: no neighbor above
            nst   <= '0;
            nln   <= '0;
            state <= S_FDEC;
          end else begin
            state <= S_CHK;  // wait for registered read
          end
        end
        S_CHK: begin
          cst <= rdata[OfsBits-1:0];
          cln <= rdata[2*OfsBits-1:OfsBits];
          if (op == OP_ALLOC) begin
            if (idx >= count) begin
              status <= ST_NOFIT;
              state  <= S_OUT;
            end else begin
              dreq.dividend <= rdata[OfsBits-1:0];
              dreq.divisor  <= align;
              dreq.start    <= 1'b1;
              state         <= S_DIV;
            end
          end else begin
            state <= S_FSCAN;
          end
        end
        S_DIV: if (drsp.done) state <= S_FIT;
        S_FIT: begin
          if ({1'b0, cln} < need) begin
            idx   <= idx + 1'b1;
            raddr <= IdxBits'(idx + 1'b1);
            state <= S_RD;
          end else begin
            granted <= cst + waste[OfsBits-1:0];
            if (cln != need[OfsBits-1:0]) begin
              if (waste != '0) begin
                if (count >= CntBits'(MaxExtents)) begin
                  status <= ST_FULL;
                  state  <= S_OUT;
                end else begin
                  // open a hole at idx, then write waste there and tail above
                  hold_ent <= {OfsBits'(cln - need[OfsBits-1:0]),
                               OfsBits'(cst + waste[OfsBits-1:0] + size)};
                  ins_ent  <= {waste[OfsBits-1:0], cst};
                  ins_at   <= idx[IdxBits-1:0];
                  ins_en   <= 1'b1;
                  shift_up <= 1'b1;
                  sidx     <= count;
                  stop     <= idx;
                  bump     <= 1'b1;
                  state    <= S_SHRD;
                end
              end else begin
                we    <= 1'b1;
                waddr <= idx[IdxBits-1:0];
                wdata <= {OfsBits'(cln - need[OfsBits-1:0]), OfsBits'(cst + size)};
                state <= S_FINAL;
              end
            end else if (waste != '0) begin
              we    <= 1'b1;
              waddr <= idx[IdxBits-1:0];
              wdata <= {waste[OfsBits-1:0], cst};
              state <= S_FINAL;
            end else begin
              shift_dn <= 1'b1;
              sidx     <= idx;
              state    <= S_SHRD;
            end
          end
        end
        S_FSCAN: begin
          // cst/cln hold entry idx (if idx < count)
          if (idx < count && cst < off) begin
            pst   <= cst;
            pln   <= cln;
            idx   <= idx + 1'b1;
            raddr <= IdxBits'(idx + 1'b1);
            state <= S_RD;
          end else begin
            nst   <= cst;
            nln   <= cln;
            state <= S_FDEC;
          end
        end
        S_FDEC: begin : fdec
          logic nx, pv;
          nx = (idx < count) && (off + size == nst);
          pv = (idx != '0) && (pst + pln == off);
          if (!nx && !pv && count >= CntBits'(MaxExtents)) begin
            status <= ST_FULL;
            state  <= S_OUT;
          end else if (nx && pv) begin
            we    <= 1'b1;
            waddr <= IdxBits'(idx - 1'b1);
            wdata <= {OfsBits'(pln + size + nln), pst};
            shift_dn <= 1'b1;
            sidx     <= idx;
            state    <= S_SHRD;
          end else if (pv) begin
            we    <= 1'b1;
            waddr <= IdxBits'(idx - 1'b1);
            wdata <= {OfsBits'(pln + size), pst};
            state <= S_FINAL;
          end else if (nx) begin
            we    <= 1'b1;
            waddr <= idx[IdxBits-1:0];
            wdata <= {OfsBits'(nln + size), off};
            state <= S_FINAL;
          end else begin
            ins_ent  <= {size, off};
            ins_at   <= idx[IdxBits-1:0];
            ins_en   <= 1'b1;
            shift_up <= 1'b1;
            sidx     <= count;
            stop     <= idx;
            state    <= S_SHRD;
          end
        end
        S_FPRV: begin
          // move one entry: the source read lands in this cycle
          we    <= 1'b1;
          waddr <= sidx[IdxBits-1:0];
          wdata <= rdata;
          sidx  <= shift_up ? sidx - 1'b1 : sidx + 1'b1;
          state <= S_SHRD;
        end
        S_SHRD: begin
          if (shift_up) begin
            if (sidx == stop) begin
              we    <= ins_en;
              waddr <= ins_at;
              wdata <= ins_ent;
              count <= count + 1'b1;
              shift_up <= 1'b0;
              state <= bump ? S_SHWR : S_FINAL;
              sidx  <= stop + 1'b1;
            end else begin
              raddr <= IdxBits'(sidx - 1'b1);
              state <= S_SHWR;
            end
          end else begin
            if (sidx + 1'b1 >= count) begin
              count <= count - 1'b1;
              state <= S_FINAL;
            end else begin
              raddr <= IdxBits'(sidx + 1'b1);
              state <= S_SHWR;
            end
          end
        end
        S_SHWR: begin
          if (bump && !shift_up) begin
            // write the tail entry above the inserted waste entry
            we    <= 1'b1;
            waddr <= sidx[IdxBits-1:0];
            wdata <= hold_ent;
            bump  <= 1'b0;
            state <= S_FINAL;
          end else begin
            state <= S_FPRV;  // hold for read latency
          end
        end
        S_FINAL: begin
          if (op == OP_ALLOC) begin
            used  <= usum[32] ? 32'hFFFF_FFFF : usum[31:0];
            tally <= (tally == 32'hFFFF_FFFF) ? tally : tally + 1'b1;
          end else begin
            used  <= (used > size) ? used - size : 32'd0;
            tally <= (tally != 0) ? tally - 1'b1 : 32'd0;
          end
          state <= S_OUT;
        end
        S_OUT: if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
